// File: design/lsch_pkg.sv
package lsch_pkg;

    localparam int MAX_SLOTS_DEF   = 64;
    localparam int TICKET_BITS_DEF = 16;
    localparam int ID_W            = 16;
    localparam int TK_IN_W         = 16;
    localparam int QUANTUM_W       = 16;
    localparam int RNG_W           = 32;
    localparam int SLOT_OUT_W      = 6;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;
    localparam logic [RNG_W-1:0]     SEED_RESET    = 32'd2463534242;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE,
        OP_SET_TICKETS,
        OP_SET_FLAGS,
        OP_PICK_RUN,
        OP_PICK_ALIVE,
        OP_TICK
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_NOT_FOUND,
        ST_NONE
    } t_status;

    typedef enum logic {
        CFG_QUANTUM,
        CFG_SEED
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDCUR,
        S_PREV,
        S_DISP,
        S_FREE,
        S_ADD,
        S_FIND,
        S_REM,
        S_UPD,
        S_SUM,
        S_DIV,
        S_WALK,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        C_NONE,
        C_LATCH,
        C_RDCUR,
        C_PREV,
        C_FAIL_FULL,
        C_FAIL_NF,
        C_FAIL_NONE,
        C_FREE,
        C_ADD,
        C_FIND,
        C_REMOVE,
        C_UPDATE,
        C_TICK,
        C_SUM,
        C_DIV_INIT,
        C_DIV,
        C_WALK,
        C_PICK,
        C_OUT
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic in_valid;
        logic full;
        logic total_zero;
        logic total_one;
        logic hit;
        logic scan_end;
        logic sum_zero;
        logic div_done;
        logic tick_pick;
        logic cur_match;
        logic out_free;
    } t_dp_status;

    function automatic logic [RNG_W-1:0] rng_next(input logic [RNG_W-1:0] s);
        logic [RNG_W-1:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

// File: design/lsch_ifs.sv
interface lsch_task_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [15:0] task_id;
    logic [15:0] ticket_count;
    logic        alive_flag;
    logic        waiting_flag;

    modport source (output valid, operation, task_id, ticket_count, alive_flag, waiting_flag,
                    input ready);
    modport sink   (input valid, operation, task_id, ticket_count, alive_flag, waiting_flag,
                    output ready);
endinterface

interface lsch_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic [15:0] chosen_id;
    logic        picked;
    logic        switch_needed;
    logic [5:0]  current_slot;
    logic        current_valid;

    modport source (output valid, status, slot_index, chosen_id, picked, switch_needed,
                    current_slot, current_valid, input ready);
    modport sink   (input valid, status, slot_index, chosen_id, picked, switch_needed,
                    current_slot, current_valid, output ready);
endinterface

interface lsch_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/lsch_ram.sv
module lsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/lsch_ctrl.sv
module lsch_ctrl import lsch_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_st,
    output t_cmd       o_cmd,
    output logic       o_in_ready
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_st.in_valid) n_state = S_RDCUR;
            S_RDCUR: n_state = S_PREV;
            S_PREV:  n_state = S_DISP;
            S_DISP: begin
                case (i_st.op)
                    OP_ADD:         n_state = i_st.full ? S_DONE : S_FREE;
                    OP_REMOVE,
                    OP_SET_TICKETS,
                    OP_SET_FLAGS:   n_state = S_FIND;
                    OP_PICK_RUN:    n_state = i_st.total_zero ? S_DONE : S_SUM;
                    OP_PICK_ALIVE:  n_state = S_SUM;
                    OP_TICK:        n_state = i_st.tick_pick ? S_SUM : S_DONE;
                    default:        n_state = S_DONE;
                endcase
            end
            S_FREE:  if (i_st.hit) n_state = S_ADD;
            S_ADD:   n_state = S_DONE;
            S_FIND: begin
                if (i_st.scan_end) begin
                    if (!i_st.hit) n_state = S_DONE;
                    else if (i_st.op == OP_REMOVE) n_state = S_REM;
                    else n_state = S_UPD;
                end
            end
            S_REM:   n_state = (i_st.cur_match && !i_st.total_one) ? S_SUM : S_DONE;
            S_UPD:   n_state = S_DONE;
            S_SUM:   if (i_st.scan_end) n_state = i_st.sum_zero ? S_DONE : S_DIV;
            S_DIV:   if (i_st.div_done) n_state = S_WALK;
            S_WALK:  if (i_st.scan_end) n_state = S_DONE;
            S_DONE:  if (i_st.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = C_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_st.in_valid) o_cmd = C_LATCH;
            end
            S_RDCUR: o_cmd = C_RDCUR;
            S_PREV:  o_cmd = C_PREV;
            S_DISP: begin
                case (i_st.op)
                    OP_ADD:      if (i_st.full) o_cmd = C_FAIL_FULL;
                    OP_PICK_RUN: if (i_st.total_zero) o_cmd = C_FAIL_NONE;
                    OP_TICK:     o_cmd = C_TICK;
                    default:     o_cmd = C_NONE;
                endcase
            end
            S_FREE:  o_cmd = C_FREE;
            S_ADD:   o_cmd = C_ADD;
            S_FIND:  o_cmd = (i_st.scan_end && !i_st.hit) ? C_FAIL_NF : C_FIND;
            S_REM:   o_cmd = C_REMOVE;
            S_UPD:   o_cmd = C_UPDATE;
            S_SUM: begin
                if (!i_st.scan_end) o_cmd = C_SUM;
                else o_cmd = i_st.sum_zero ? C_FAIL_NONE : C_DIV_INIT;
            end
            S_DIV:   o_cmd = C_DIV;
            S_WALK:  o_cmd = i_st.scan_end ? C_PICK : C_WALK;
            S_DONE:  if (i_st.out_free) o_cmd = C_OUT;
            default: o_cmd = C_NONE;
        endcase
    end
endmodule

// File: design/lsch_dp.sv
module lsch_dp import lsch_pkg::*; #(
    parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_dp_status            o_st,
    input  logic                  i_in_valid,
    input  logic [2:0]            i_operation,
    input  logic [ID_W-1:0]       i_task_id,
    input  logic [TK_IN_W-1:0]    i_ticket_count,
    input  logic                  i_alive_flag,
    input  logic                  i_waiting_flag,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_index,
    input  logic [RNG_W-1:0]      i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [1:0]            o_status,
    output logic [SLOT_OUT_W-1:0] o_slot_index,
    output logic [ID_W-1:0]       o_chosen_id,
    output logic                  o_picked,
    output logic                  o_switch_needed,
    output logic [SLOT_OUT_W-1:0] o_current_slot,
    output logic                  o_current_valid
);
    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W  = TICKET_BITS + IDX_W;
    localparam int D_W    = ID_W + TICKET_BITS + 2;
    localparam int DCNT_W = $clog2(RNG_W + 1);
    localparam logic [IDX_W-1:0]  LAST     = IDX_W'(MAX_SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(MAX_SLOTS);
    localparam logic [DCNT_W-1:0] DIV_END  = DCNT_W'(RNG_W);

    logic                   r_used [MAX_SLOTS];
    logic [CNT_W-1:0]       r_total;
    logic [IDX_W-1:0]       r_cur_idx;
    logic                   r_cur_set;
    logic [QUANTUM_W-1:0]   r_qcount;
    logic [QUANTUM_W-1:0]   r_quantum;
    logic [RNG_W-1:0]       r_rng;

    t_op                    r_op;
    logic [ID_W-1:0]        r_id;
    logic [TICKET_BITS-1:0] r_tk;
    logic                   r_alive;
    logic                   r_wait;

    logic                   r_prev_ok;
    logic [IDX_W-1:0]       r_prev_idx;
    logic                   r_soft;

    logic [IDX_W-1:0]       r_idx;
    logic                   r_issued_all;
    logic                   r_chk_v;
    logic [IDX_W-1:0]       r_chk_idx;
    logic                   r_end;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [D_W-1:0]         r_hit_data;

    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       r_run;
    logic [RNG_W-1:0]       r_div;
    logic [SUM_W-1:0]       r_rem;
    logic [DCNT_W-1:0]      r_dcnt;

    t_status                r_status;
    logic [IDX_W-1:0]       r_slot;
    logic [ID_W-1:0]        r_chosen;
    logic                   r_picked;
    logic                   r_sw;

    logic [D_W-1:0]         ram_q;
    logic [D_W-1:0]         ram_wdata;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;

    logic [ID_W-1:0]        q_id;
    logic [TICKET_BITS-1:0] q_tk;
    logic                   q_alive;
    logic                   q_wait;
    logic [ID_W-1:0]        h_id;
    logic [TICKET_BITS-1:0] h_tk;
    logic                   h_alive;
    logic                   h_wait;

    logic [TICKET_BITS-1:0] n_tk;
    logic [TICKET_BITS-1:0] tk_add;
    logic                   runnable;
    logic                   chk_act;
    logic                   elig;
    logic [SUM_W-1:0]       n_run;
    logic                   scan_cmd;
    logic                   step;
    logic [QUANTUM_W-1:0]   q_inc;
    logic                   cur_valid;
    logic [SUM_W:0]         rem_sh;
    logic [SUM_W:0]         rem_sub;
    logic [RNG_W-1:0]       n_rng;

    // fit the 16-bit ticket field to the internal ticket width
    always_comb begin
        for (int b = 0; b < TICKET_BITS; b++) begin
            n_tk[b] = (b < TK_IN_W) ? i_ticket_count[b] : 1'b0;
        end
    end

    assign q_id    = ram_q[D_W-1 -: ID_W];
    assign q_tk    = ram_q[TICKET_BITS+1:2];
    assign q_alive = ram_q[1];
    assign q_wait  = ram_q[0];
    assign h_id    = r_hit_data[D_W-1 -: ID_W];
    assign h_tk    = r_hit_data[TICKET_BITS+1:2];
    assign h_alive = r_hit_data[1];
    assign h_wait  = r_hit_data[0];

    assign tk_add    = (r_tk == '0) ? TICKET_BITS'(1) : r_tk;
    assign runnable  = (r_op != OP_PICK_ALIVE);
    assign chk_act   = r_chk_v && !r_end && !r_hit;
    assign elig      = r_used[r_chk_idx] && q_alive && (!runnable || !q_wait);
    assign n_run     = r_run + SUM_W'(q_tk);
    assign scan_cmd  = (i_cmd == C_FIND) || (i_cmd == C_SUM) || (i_cmd == C_WALK);
    assign step      = scan_cmd && !r_end && !r_hit;
    assign q_inc     = r_qcount + QUANTUM_W'(1);
    assign cur_valid = r_cur_set && r_used[r_cur_idx];
    assign rem_sh    = {r_rem, r_div[RNG_W-1]};
    assign rem_sub   = rem_sh - {1'b0, r_sum};
    assign n_rng     = rng_next(r_rng);
    assign ram_raddr = (i_cmd == C_RDCUR) ? r_cur_idx : r_idx;
    assign ram_we    = (i_cmd == C_ADD) || (i_cmd == C_UPDATE);

    always_comb begin
        if (i_cmd == C_ADD) begin
            ram_wdata = {r_id, tk_add, r_alive, r_wait};
        end else if (r_op == OP_SET_TICKETS) begin
            ram_wdata = {h_id, (r_tk != '0) ? r_tk : h_tk, h_alive, h_wait};
        end else begin
            ram_wdata = {h_id, h_tk, r_alive, r_wait};
        end
    end

    lsch_ram #(.WIDTH(D_W), .DEPTH(MAX_SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_hit_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        o_st.op         = r_op;
        o_st.in_valid   = i_in_valid;
        o_st.full       = (r_total == FULL_CNT);
        o_st.total_zero = (r_total == '0);
        o_st.total_one  = (r_total == CNT_W'(1));
        o_st.hit        = r_hit;
        o_st.scan_end   = r_end || r_hit;
        o_st.sum_zero   = (r_sum == '0);
        o_st.div_done   = (r_dcnt == DIV_END);
        o_st.tick_pick  = (q_inc >= r_quantum) && cur_valid;
        o_st.cur_match  = r_cur_set && (r_cur_idx == r_hit_idx);
        o_st.out_free   = !o_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_used[i] <= 1'b0;
            end
            r_total      <= '0;
            r_cur_idx    <= '0;
            r_cur_set    <= 1'b0;
            r_qcount     <= '0;
            r_quantum    <= QUANTUM_RESET;
            r_rng        <= SEED_RESET;
            r_chk_v      <= 1'b0;
            r_end        <= 1'b0;
            r_hit        <= 1'b0;
            r_issued_all <= 1'b0;
            r_dcnt       <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            // scan pipeline: address goes out, data is checked in the next cycle
            if (step) begin
                r_chk_v   <= !r_issued_all;
                r_chk_idx <= r_idx;
                r_idx     <= r_idx + IDX_W'(1);
                if (r_idx == LAST) r_issued_all <= 1'b1;
            end else begin
                r_chk_v <= 1'b0;
            end
            if (chk_act && scan_cmd) begin
                if (r_chk_idx == LAST) r_end <= 1'b1;
                case (i_cmd)
                    C_FIND: begin
                        if (r_used[r_chk_idx] && q_id == r_id) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_chk_idx;
                            r_hit_data <= ram_q;
                        end
                    end
                    C_SUM: if (elig) r_sum <= r_sum + SUM_W'(q_tk);
                    C_WALK: begin
                        if (elig) begin
                            r_run <= n_run;
                            if (r_rem < n_run) begin
                                r_hit      <= 1'b1;
                                r_hit_idx  <= r_chk_idx;
                                r_hit_data <= ram_q;
                            end
                        end
                    end
                    default: r_end <= r_end;
                endcase
            end

            if (o_out_valid && i_out_ready && i_cmd != C_OUT) o_out_valid <= 1'b0;

            case (i_cmd)
                C_LATCH: begin
                    r_op     <= t_op'(i_operation);
                    r_id     <= i_task_id;
                    r_tk     <= n_tk;
                    r_alive  <= i_alive_flag;
                    r_wait   <= i_waiting_flag;
                    r_status <= ST_OK;
                    r_slot   <= '0;
                    r_chosen <= '0;
                    r_picked <= 1'b0;
                    r_sw     <= 1'b0;
                    r_soft   <= 1'b0;
                end
                C_PREV: begin
                    r_prev_ok    <= cur_valid && q_alive;
                    r_prev_idx   <= r_cur_idx;
                    r_idx        <= '0;
                    r_issued_all <= 1'b0;
                    r_end        <= 1'b0;
                    r_hit        <= 1'b0;
                    r_sum        <= '0;
                end
                C_FAIL_FULL: r_status <= ST_FULL;
                C_FAIL_NF:   r_status <= ST_NOT_FOUND;
                C_FAIL_NONE: if (!r_soft) r_status <= ST_NONE;
                C_FREE: begin
                    if (!r_hit) begin
                        if (!r_used[r_idx]) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_idx;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                C_ADD: begin
                    r_used[r_hit_idx] <= 1'b1;
                    r_total           <= r_total + CNT_W'(1);
                    r_slot            <= r_hit_idx;
                    if (!r_cur_set) begin
                        r_cur_idx <= r_hit_idx;
                        r_cur_set <= 1'b1;
                    end
                end
                C_REMOVE: begin
                    r_used[r_hit_idx] <= 1'b0;
                    r_total           <= r_total - CNT_W'(1);
                    r_slot            <= r_hit_idx;
                    r_soft            <= 1'b1;
                    if (r_cur_set && r_cur_idx == r_hit_idx) r_prev_ok <= 1'b0;
                    r_idx        <= '0;
                    r_issued_all <= 1'b0;
                    r_end        <= 1'b0;
                    r_hit        <= 1'b0;
                    r_sum        <= '0;
                end
                C_UPDATE: r_slot <= r_hit_idx;
                C_TICK: r_qcount <= (q_inc >= r_quantum) ? '0 : q_inc;
                C_DIV_INIT: begin
                    r_rng        <= n_rng;
                    r_div        <= n_rng;
                    r_rem        <= '0;
                    r_dcnt       <= '0;
                    r_run        <= '0;
                    r_idx        <= '0;
                    r_issued_all <= 1'b0;
                    r_end        <= 1'b0;
                    r_hit        <= 1'b0;
                end
                C_DIV: begin
                    // one remainder bit per cycle
                    if (r_dcnt != DIV_END) begin
                        r_rem  <= rem_sub[SUM_W] ? rem_sh[SUM_W-1:0] : rem_sub[SUM_W-1:0];
                        r_div  <= {r_div[RNG_W-2:0], 1'b0};
                        r_dcnt <= r_dcnt + DCNT_W'(1);
                    end
                end
                C_PICK: begin
                    r_cur_idx <= r_hit_idx;
                    r_cur_set <= 1'b1;
                    r_picked  <= 1'b1;
                    r_slot    <= r_hit_idx;
                    r_chosen  <= h_id;
                    r_sw      <= !r_prev_ok || (r_prev_idx != r_hit_idx);
                end
                C_OUT: begin
                    o_out_valid     <= 1'b1;
                    o_status        <= r_status;
                    o_slot_index    <= SLOT_OUT_W'(r_slot);
                    o_chosen_id     <= r_chosen;
                    o_picked        <= r_picked;
                    o_switch_needed <= r_sw;
                    o_current_slot  <= SLOT_OUT_W'(r_cur_idx);
                    o_current_valid <= cur_valid;
                end
                default: r_op <= r_op;
            endcase

            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_QUANTUM: r_quantum <= i_cfg_data[QUANTUM_W-1:0];
                    CFG_SEED:    r_rng     <= i_cfg_data;
                    default:     r_quantum <= r_quantum;
                endcase
            end
        end
    end
endmodule

// File: design/lottery_process_scheduler.sv
// Lottery scheduler over a table of task slots.
// i_task carries one command transaction (add, remove, set tickets, set flags,
// pick runnable, pick alive, tick); o_result returns exactly one result per
// command. i_cfg writes quantum_ticks (index 0) or rng_seed (index 1); writing
// the seed also reloads the generator. Write configuration only while idle.
// Commands are handled one at a time: i_task.ready is high only in the idle
// state. A plain command passes through the read-current, previous and dispatch
// states; an add or id search then scans the table, and a lottery pick sums the
// tickets, runs a bit-serial modulo and walks the table for the winner.
// The slot table is read through one RAM port, one slot per cycle.
// The result sits in an output register; if the receiver stalls, the block
// holds it and can take the next command, but waits before giving its result.
// Reset (synchronous, active low) empties the table, clears the current task
// and quantum count, and restores quantum 10 and the default seed.
module lottery_process_scheduler import lsch_pkg::*; #(
    parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    lsch_task_if.sink     i_task,
    lsch_result_if.source o_result,
    lsch_cfg_if.sink      i_cfg
);
    t_dp_status st;
    t_cmd       cmd;
    logic       in_ready;

    assign i_task.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    lsch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    lsch_dp #(.MAX_SLOTS(MAX_SLOTS), .TICKET_BITS(TICKET_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_in_valid      (i_task.valid),
        .i_operation     (i_task.operation),
        .i_task_id       (i_task.task_id),
        .i_ticket_count  (i_task.ticket_count),
        .i_alive_flag    (i_task.alive_flag),
        .i_waiting_flag  (i_task.waiting_flag),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_status        (o_result.status),
        .o_slot_index    (o_result.slot_index),
        .o_chosen_id     (o_result.chosen_id),
        .o_picked        (o_result.picked),
        .o_switch_needed (o_result.switch_needed),
        .o_current_slot  (o_result.current_slot),
        .o_current_valid (o_result.current_valid)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_task.valid && i_task.ready |=> !i_task.ready)
        else $error("command accepted while another is in progress");

    a_pick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.picked |-> o_result.status == ST_OK)
        else $error("pick reported with failing status");

    a_pick_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.picked |->
            o_result.current_valid && o_result.current_slot == o_result.slot_index)
        else $error("winner is not the current task");

    a_switch_needs_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.switch_needed |-> o_result.picked)
        else $error("switch flagged without a pick");
endmodule
